### hdl/assert_macros.svh
// Assertion macros shared by the thermistor temperature RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held outside reset.
`define ASSERT_DIS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("thermistor_temperature: check failed");

// Check held at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("thermistor_temperature: check failed");

`endif

### hdl/thm_pkg.sv
// Shared types and constants for the thermistor temperature pipeline.
// No dependencies; imported by every module and used by the channel interfaces.
package thm_pkg;

  localparam int VOLT_W   = 12;
  localparam int SUPPLY_W = 12;
  localparam int SERIES_W = 20;
  localparam int COEF_W   = 48;
  localparam int KOFF_W   = 16;
  localparam int TEMP_W   = 16;
  localparam int NUM_W    = SERIES_W + VOLT_W;
  localparam int LOG_FRAC = 30;
  localparam int LG_W     = 36;
  localparam int INV_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [27:0] LN2_Q28     = 28'd186065279;
  localparam logic [63:0] HUNDRED_Q56 = 64'd100 << 56;

  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KOFF   = 3'd5;

  localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 12'd3300;
  localparam logic [SERIES_W-1:0] SERIES_RST = 20'd10000;
  localparam logic [COEF_W-1:0]   COEF_A_RST = 48'd81363500000000;
  localparam logic [COEF_W-1:0]   COEF_B_RST = 48'd16870600000000;
  localparam logic [COEF_W-1:0]   COEF_C_RST = 48'd6317590000;
  localparam logic [KOFF_W-1:0]   KOFF_RST   = 16'd27315;

  typedef struct packed {
    logic [SUPPLY_W-1:0] supply_mv;
    logic [SERIES_W-1:0] series_resistance_ohm;
    logic [COEF_W-1:0]   coef_a;
    logic [COEF_W-1:0]   coef_b;
    logic [COEF_W-1:0]   coef_c;
    logic [KOFF_W-1:0]   kelvin_offset_centi;
  } cfg_t;

  // Per-stage tag: word present, and sample inside the valid range.
  typedef struct packed {
    logic vld;
    logic ok;
  } tag_t;

endpackage

### hdl/thm_if.sv
// Valid/ready channel interfaces for the sample and result words.
// Depends on thm_pkg for field widths.
interface thm_in_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [thm_pkg::VOLT_W-1:0]    divider_mv;
  modport source (output valid, output divider_mv, input ready);
  modport sink   (input valid, input divider_mv, output ready);
endinterface

interface thm_out_if (input logic clk);
  logic                          valid;
  logic                          ready;
  logic signed [thm_pkg::TEMP_W-1:0] temperature_centi_c;
  logic                          valid_res;
  modport source (output valid, output temperature_centi_c, output valid_res, input ready);
  modport sink   (input valid, input temperature_centi_c, input valid_res, output ready);
endinterface

### hdl/thermistor_temperature.sv
// Thermistor temperature, Steinhart-Hart, fully pipelined fixed point.
// Throughput: one word per cycle; the whole pipe advances together and holds
// when the result word waits at the output register.
// Reset (synchronous, rst high): clears all stage valid bits and loads the
// registers with their defaults (3300 mV, 10 kOhm, standard coefficients).
module thermistor_temperature (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [thm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thm_pkg::CFG_DATA_W-1:0]    cfg_data,
  thm_in_if.sink                            sample,
  thm_out_if.source                         result
);
  import thm_pkg::*;
  `include "assert_macros.svh"

  cfg_t cfg;

  // Register file: no read-back, unused indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supply_mv             <= SUPPLY_RST;
      cfg.series_resistance_ohm <= SERIES_RST;
      cfg.coef_a                <= COEF_A_RST;
      cfg.coef_b                <= COEF_B_RST;
      cfg.coef_c                <= COEF_C_RST;
      cfg.kelvin_offset_centi   <= KOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUPPLY: cfg.supply_mv             <= cfg_data[SUPPLY_W-1:0];
        REG_SERIES: cfg.series_resistance_ohm <= cfg_data[SERIES_W-1:0];
        REG_COEF_A: cfg.coef_a                <= cfg_data[COEF_W-1:0];
        REG_COEF_B: cfg.coef_b                <= cfg_data[COEF_W-1:0];
        REG_COEF_C: cfg.coef_c                <= cfg_data[COEF_W-1:0];
        REG_KOFF:   cfg.kelvin_offset_centi   <= cfg_data[KOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage unless the result word is stalled at the output.
  logic adv;
  tag_t tag_out;
  assign adv          = !tag_out.vld || result.ready;
  assign sample.ready = adv;

  // Stage 1: divider numerator series*v, denominator supply-v, range check.
  tag_t                tag1;
  logic [NUM_W-1:0]    num1;
  logic [SUPPLY_W-1:0] den1;
  logic                in_ok;

  assign in_ok = (sample.divider_mv != '0) && (sample.divider_mv < cfg.supply_mv)
               && (cfg.series_resistance_ohm != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (adv) begin
      tag1 <= '{vld: sample.valid, ok: in_ok};
    end
    if (adv) begin
      num1 <= NUM_W'(cfg.series_resistance_ohm) * NUM_W'(sample.divider_mv);
      den1 <= cfg.supply_mv - sample.divider_mv;
    end
  end

  tag_t             tag_lg, tag_inv;
  logic signed [LG_W-1:0]  lg;
  logic signed [INV_W-1:0] inv;

  thm_log2 u_log2 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag1),
    .num     (num1),
    .den     (den1),
    .tag_out (tag_lg),
    .lg      (lg)
  );

  thm_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .tag_in  (tag_lg),
    .lg      (lg),
    .tag_out (tag_inv),
    .inv     (inv)
  );

  thm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .tag_in  (tag_inv),
    .inv     (inv),
    .tag_out (tag_out),
    .temp    (result.temperature_centi_c)
  );

  assign result.valid     = tag_out.vld;
  assign result.valid_res = tag_out.ok;

  // An out-of-range sample always reads as zero.
  `ASSERT_DIS(a_bad_is_zero, clk, rst,
    result.valid && !result.valid_res |-> result.temperature_centi_c == '0)
  // Input is held off only by a waiting result word.
  `ASSERT_DIS(a_stall_cause, clk, rst, !sample.ready |-> result.valid)
  // Nothing leaves the pipe right after reset.
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !result.valid)

endmodule

### hdl/thm_log2.sv
// Log2 difference of divider numerator and denominator, Q30, by repeated squaring.
// Depends on thm_pkg; 32 stages: normalize, one squaring per stage, then subtract.
module thm_log2 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  thm_pkg::tag_t                 tag_in,
  input  logic [thm_pkg::NUM_W-1:0]     num,
  input  logic [thm_pkg::SUPPLY_W-1:0]  den,
  output thm_pkg::tag_t                 tag_out,
  output logic signed [thm_pkg::LG_W-1:0] lg
);
  import thm_pkg::*;

  function automatic logic [4:0] msb_idx(input logic [31:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k = i[4:0];
    end
    return k;
  endfunction

  function automatic logic [30:0] norm(input logic [31:0] x, input logic [4:0] k);
    logic [31:0] s;
    if (k <= 5'd30) s = x << (5'd30 - k);
    else s = x >> 1;
    return s[30:0];
  endfunction

  logic [30:0] m_n [0:LOG_FRAC];
  logic [30:0] m_d [0:LOG_FRAC];
  logic [29:0] f_n [0:LOG_FRAC];
  logic [29:0] f_d [0:LOG_FRAC];
  logic [4:0]  k_n [0:LOG_FRAC];
  logic [4:0]  k_d [0:LOG_FRAC];
  tag_t        tag_q [0:LOG_FRAC];

  logic [31:0] num_x, den_x;
  logic [4:0]  kn0, kd0;

  assign num_x = num;
  assign den_x = {20'b0, den};
  assign kn0   = msb_idx(num_x);
  assign kd0   = msb_idx(den_x);

  // Normalize mantissa into [1,2) in Q30.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q[0] <= '0;
    end else if (adv) begin
      tag_q[0] <= tag_in;
    end
    if (adv) begin
      k_n[0] <= kn0;
      k_d[0] <= kd0;
      m_n[0] <= norm(num_x, kn0);
      m_d[0] <= norm(den_x, kd0);
      f_n[0] <= '0;
      f_d[0] <= '0;
    end
  end

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic [61:0] sq_n, sq_d;
    logic [31:0] t_n, t_d;
    logic [29:0] b_n, b_d;
    assign sq_n = {31'b0, m_n[i]} * {31'b0, m_n[i]};
    assign sq_d = {31'b0, m_d[i]} * {31'b0, m_d[i]};
    assign t_n  = sq_n[61:30];
    assign t_d  = sq_d[61:30];
    assign b_n  = 30'(t_n[31]) << (LOG_FRAC - 1 - i);
    assign b_d  = 30'(t_d[31]) << (LOG_FRAC - 1 - i);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i+1] <= '0;
      end else if (adv) begin
        tag_q[i+1] <= tag_q[i];
      end
      if (adv) begin
        m_n[i+1] <= t_n[31] ? t_n[31:1] : t_n[30:0];
        m_d[i+1] <= t_d[31] ? t_d[31:1] : t_d[30:0];
        f_n[i+1] <= f_n[i] | b_n;
        f_d[i+1] <= f_d[i] | b_d;
        k_n[i+1] <= k_n[i];
        k_d[i+1] <= k_d[i];
      end
    end
  end

  // Subtract the two Q30 logs.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_q[LOG_FRAC];
    end
    if (adv) begin
      lg <= $signed({1'b0, k_n[LOG_FRAC], f_n[LOG_FRAC]})
          - $signed({1'b0, k_d[LOG_FRAC], f_d[LOG_FRAC]});
    end
  end

endmodule

### hdl/thm_poly.sv
// Natural log scaling and Steinhart-Hart cubic, Q56 sum of three terms.
// Depends on thm_pkg; 8 stages, wide products split in two partials.
module thm_poly (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  thm_pkg::cfg_t                   cfg,
  input  thm_pkg::tag_t                   tag_in,
  input  logic signed [thm_pkg::LG_W-1:0] lg,
  output thm_pkg::tag_t                   tag_out,
  output logic signed [thm_pkg::INV_W-1:0] inv
);
  import thm_pkg::*;

  tag_t tag_q [1:7];
  logic sgn_q [1:6];

  logic [34:0] lg_mag, ln_mag2, ln_mag3;
  logic [39:0] lsq;
  logic [54:0] plo, phi;
  logic [58:0] blo, bhi;
  logic [44:0] lcu;
  logic [52:0] bt_mag5, bt_mag6;
  logic [68:0] clo, chi;
  logic signed [63:0] bterm, cterm;

  logic [47:0] bmag, cmag;
  logic        bneg, cneg;
  logic [35:0] lg_neg;
  logic [62:0] p2;
  logic [69:0] p3;
  logic [74:0] lcu_full;
  logic [82:0] b_full;
  logic [92:0] c_full;
  logic [62:0] ct_mag;

  assign bneg   = cfg.coef_b[COEF_W-1];
  assign cneg   = cfg.coef_c[COEF_W-1];
  assign bmag   = bneg ? (~cfg.coef_b + 48'd1) : cfg.coef_b;
  assign cmag   = cneg ? (~cfg.coef_c + 48'd1) : cfg.coef_c;
  assign lg_neg = -lg;
  assign p2     = 63'(lg_mag) * 63'(LN2_Q28);
  assign p3     = 70'(ln_mag2) * 70'(ln_mag2);
  assign lcu_full = (75'(phi) << 20) + 75'(plo);
  assign b_full   = (83'(bhi) << 24) + 83'(blo);
  assign c_full   = (93'(chi) << 24) + 93'(clo);
  assign ct_mag   = c_full[92:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 7; s++) tag_q[s] <= '0;
      tag_out <= '0;
    end else if (adv) begin
      tag_q[1] <= tag_in;
      for (int s = 2; s <= 7; s++) tag_q[s] <= tag_q[s-1];
      tag_out <= tag_q[7];
    end
    if (adv) begin
      sgn_q[1] <= lg[LG_W-1];
      for (int s = 2; s <= 6; s++) sgn_q[s] <= sgn_q[s-1];
      lg_mag   <= lg[LG_W-1] ? lg_neg[34:0] : lg[34:0];
      ln_mag2  <= p2[62:28];
      ln_mag3  <= ln_mag2;
      lsq      <= p3[69:30];
      plo      <= 55'(lsq[19:0]) * 55'(ln_mag3);
      phi      <= 55'(lsq[39:20]) * 55'(ln_mag3);
      blo      <= 59'(bmag[23:0]) * 59'(ln_mag3);
      bhi      <= 59'(bmag[47:24]) * 59'(ln_mag3);
      lcu      <= lcu_full[74:30];
      bt_mag5  <= b_full[82:30];
      clo      <= 69'(cmag[23:0]) * 69'(lcu);
      chi      <= 69'(cmag[47:24]) * 69'(lcu);
      bt_mag6  <= bt_mag5;
      bterm    <= (bneg ^ sgn_q[6]) ? -$signed(64'(bt_mag6)) : $signed(64'(bt_mag6));
      cterm    <= (cneg ^ sgn_q[6]) ? -$signed(64'(ct_mag)) : $signed(64'(ct_mag));
      inv      <= $signed({{16{cfg.coef_a[COEF_W-1]}}, cfg.coef_a}) + bterm + cterm;
    end
  end

endmodule

### hdl/thm_div.sv
// Reciprocal 100*2^56/|1/T| by restoring division, offset and saturation.
// Depends on thm_pkg; 20 stages: sign, setup, one quotient bit per division stage, output.
module thm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  thm_pkg::cfg_t                    cfg,
  input  thm_pkg::tag_t                    tag_in,
  input  logic signed [thm_pkg::INV_W-1:0] inv,
  output thm_pkg::tag_t                    tag_out,
  output logic signed [thm_pkg::TEMP_W-1:0] temp
);
  import thm_pkg::*;

  localparam int QW = 17;

  tag_t        tag0;
  logic        sgn0;
  logic [63:0] mag0;
  logic [63:0] numr;

  tag_t        tag_q [0:QW];
  logic        sgn_q [0:QW];
  logic        ovf_q [0:QW];
  logic [63:0] mag_q [0:QW];
  logic [63:0] r_q   [0:QW];
  logic [QW-1:0] q_q [0:QW];

  logic signed [18:0] qs, offs, tq;

  assign numr = HUNDRED_Q56 + {1'b0, mag0[63:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0     <= '0;
      tag_q[0] <= '0;
    end else if (adv) begin
      tag0     <= tag_in;
      tag_q[0] <= tag0;
    end
    if (adv) begin
      sgn0     <= inv[INV_W-1];
      mag0     <= inv[INV_W-1] ? 64'(-inv) : 64'(inv);
      sgn_q[0] <= sgn0;
      mag_q[0] <= mag0;
      r_q[0]   <= numr;
      q_q[0]   <= '0;
      ovf_q[0] <= {17'b0, numr} >= {mag0, 17'b0};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [80:0] dsh;
    logic        ge;
    assign dsh = 81'(mag_q[j]) << (QW - 1 - j);
    assign ge  = 81'(r_q[j]) >= dsh;
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[j+1] <= '0;
      end else if (adv) begin
        tag_q[j+1] <= tag_q[j];
      end
      if (adv) begin
        sgn_q[j+1] <= sgn_q[j];
        ovf_q[j+1] <= ovf_q[j];
        mag_q[j+1] <= mag_q[j];
        r_q[j+1]   <= ge ? (r_q[j] - dsh[63:0]) : r_q[j];
        q_q[j+1]   <= q_q[j] | (QW'(ge) << (QW - 1 - j));
      end
    end
  end

  assign qs   = $signed({2'b0, q_q[QW]});
  assign offs = $signed({3'b0, cfg.kelvin_offset_centi});
  assign tq   = sgn_q[QW] ? (-qs - offs) : (qs - offs);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (adv) begin
      tag_out <= tag_q[QW];
    end
    if (adv) begin
      if (!tag_q[QW].ok) temp <= '0;
      else if (ovf_q[QW]) temp <= sgn_q[QW] ? -16'sd32768 : 16'sd32767;
      else if (tq > 19'sd32767) temp <= 16'sd32767;
      else if (tq < -19'sd32768) temp <= -16'sd32768;
      else temp <= tq[15:0];
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for thermistor_temperature: directed table, register extremes, then random samples.
// Depends on thm_pkg and the channel interfaces thm_in_if / thm_out_if.
module testbench;
  import thm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  thm_in_if  sample (clk);
  thm_out_if result (clk);

  thermistor_temperature dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(sample.sink), .result(result.source)
  );

  localparam int PIPE_DEPTH = 61;
  localparam int CYCLE_LIMIT = 1000000;
  // Index past the register list; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     ok;
  } reading_t;

  // Shadow copy of the registers.
  logic [SUPPLY_W-1:0] sh_supply;
  logic [SERIES_W-1:0] sh_series;
  logic signed [COEF_W-1:0] sh_a, sh_b, sh_c;
  logic [KOFF_W-1:0] sh_koff;

  reading_t pending_readings[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;

  // Multiply, then shift with truncation toward zero and saturation to the signed 64-bit range.
  function automatic longint mul_shift(longint a, longint b, int sh);
    logic signed [127:0] p;
    logic [127:0] m;
    logic [127:0] r;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(signed'(a)) * 128'(signed'(b));
    m = p[127] ? -p : p;
    r = m >> sh;
    if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // Binary log in Q30 by repeated squaring of the normalized mantissa.
  function automatic longint log2_q30(logic [63:0] x);
    int k;
    logic [63:0] m, f;
    k = 0;
    f = '0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? x << (30 - k) : x >> (k - 30);
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      if ((m >> 31) != 0) begin
        m = m >> 1;
        f[29 - i] = 1'b1;
      end
    end
    return longint'((64'(k) << 30) | f);
  endfunction

  function automatic reading_t predict_reading(logic [VOLT_W-1:0] v);
    reading_t r;
    longint lg, ln, lsq, lcu, inv, t;
    logic [63:0] mag, q;
    r.temp = '0;
    r.ok = 1'b0;
    if (v == 0 || v >= sh_supply || sh_series == 0) return r;
    lg = log2_q30(64'(sh_series) * 64'(v)) - log2_q30(64'(sh_supply - v));
    ln = mul_shift(lg, 64'(LN2_Q28), 28);
    lsq = mul_shift(ln, ln, 30);
    lcu = mul_shift(lsq, ln, 30);
    inv = longint'(sh_a) + mul_shift(longint'(sh_b), ln, 30)
        + mul_shift(longint'(sh_c), lcu, 30);
    if (inv == 0) begin
      t = 32767;
    end else begin
      mag = inv < 0 ? -inv : inv;
      q = (HUNDRED_Q56 + mag / 2) / mag;
      t = (inv < 0 ? -longint'(q) : longint'(q)) - longint'(sh_koff);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
    end
    r.temp = t[15:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SUPPLY: sh_supply = val[SUPPLY_W-1:0];
      REG_SERIES: sh_series = val[SERIES_W-1:0];
      REG_COEF_A: sh_a = val;
      REG_COEF_B: sh_b = val;
      REG_COEF_C: sh_c = val;
      REG_KOFF:   sh_koff = val[KOFF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one word; hold valid until the handshake completes. Leaves valid high.
  task automatic send_voltage(logic [VOLT_W-1:0] v);
    sample.valid <= 1'b1;
    sample.divider_mv <= v;
    pending_readings.push_back(predict_reading(v));
    do @(posedge clk); while (!sample.ready);
  endtask

  // Send with random bursts and gaps; drop valid only during a gap.
  task automatic send_paced(logic [VOLT_W-1:0] v, ref int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sample.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_voltage(v);
  endtask

  task automatic drain;
    sample.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  // Receiver: stall on a pattern of its own; yield to a long hold-off.
  initial begin
    int phase;
    phase = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) result.ready <= 1'b0;
      else if (phase % 300 < 100) result.ready <= 1'b1;
      else result.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected result word: temperature_centi_c %0d", result.temperature_centi_c);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (result.valid_res !== want.ok) begin
          $error("valid_res: expected %0b, got %0b", want.ok, result.valid_res);
          fail_count++;
        end
        if (result.temperature_centi_c !== want.temp) begin
          $error("temperature_centi_c: expected %0d, got %0d",
                 want.temp, result.temperature_centi_c);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    logic [VOLT_W-1:0] volt;
    bit                typed;   // expected value written in the row
    logic signed [TEMP_W-1:0] temp;
    logic              ok;
  } stim_row_t;

  // Directed table under the reset registers: edges of the input range, then mid-range voltages.
  stim_row_t directed_rows[] = '{
    '{12'd0,    1'b1, 16'sd0, 1'b0},  // zero voltage
    '{12'd3300, 1'b1, 16'sd0, 1'b0},  // at supply
    '{12'd3301, 1'b1, 16'sd0, 1'b0},  // above supply
    '{12'd4095, 1'b1, 16'sd0, 1'b0},  // top of the field
    '{12'd1,    1'b0, 16'sd0, 1'b0},
    '{12'd3299, 1'b0, 16'sd0, 1'b0},
    '{12'd1650, 1'b0, 16'sd0, 1'b0},
    '{12'd2048, 1'b0, 16'sd0, 1'b0},
    '{12'd1024, 1'b0, 16'sd0, 1'b0},
    '{12'd2730, 1'b0, 16'sd0, 1'b0}
  };

  logic [CFG_DATA_W-1:0] coef_pick;

  function automatic logic [CFG_DATA_W-1:0] rand_coef();
    return CFG_DATA_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    int burst_left;
    reading_t want;
    burst_left = 0;
    sample.valid = 1'b0;
    sample.divider_mv = '0;
    sh_supply = SUPPLY_RST; sh_series = SERIES_RST;
    sh_a = COEF_A_RST; sh_b = COEF_B_RST; sh_c = COEF_C_RST; sh_koff = KOFF_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; typed expectations override the predictor.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want.temp = directed_rows[i].temp;
        want.ok = directed_rows[i].ok;
        sample.valid <= 1'b1;
        sample.divider_mv <= directed_rows[i].volt;
        pending_readings.push_back(want);
        do @(posedge clk); while (!sample.ready);
      end else begin
        send_voltage(directed_rows[i].volt);
      end
    end
    drain();

    // Register extremes: zero-sum, negative-sum, full-scale, zero series, unused index, zero supply.
    write_reg(REG_COEF_A, '0); write_reg(REG_COEF_B, '0); write_reg(REG_COEF_C, '0);
    send_voltage(12'd1000);                    // sum of terms zero: saturate high
    drain();
    write_reg(REG_COEF_A, 48'h8000_0000_0000); // most negative constant
    write_reg(REG_KOFF, 48'hFFFF);
    send_voltage(12'd500); send_voltage(12'd3000);
    drain();
    write_reg(REG_COEF_A, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_COEF_B, 48'h7FFF_FFFF_FFFF);
    write_reg(REG_COEF_C, 48'h8000_0000_0000);
    write_reg(REG_KOFF, '0);
    write_reg(REG_SERIES, 48'hFFFFF);
    write_reg(REG_SUPPLY, 48'hFFF);
    send_voltage(12'd1); send_voltage(12'd4094); send_voltage(12'd4095);
    drain();
    write_reg(REG_SERIES, '0);                 // series resistor zero
    write_reg(REG_NONE, 48'd123);              // unused index, ignored
    send_voltage(12'd100);
    drain();
    write_reg(REG_SUPPLY, '0);                 // supply zero: all invalid
    write_reg(REG_SERIES, 48'd1);
    send_voltage(12'd1); send_voltage(12'd2048);
    drain();

    // Random phases over several register settings.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(REG_SUPPLY, 48'(SUPPLY_RST)); write_reg(REG_SERIES, 48'(SERIES_RST));
        write_reg(REG_COEF_A, COEF_A_RST); write_reg(REG_COEF_B, COEF_B_RST);
        write_reg(REG_COEF_C, COEF_C_RST); write_reg(REG_KOFF, 48'(KOFF_RST));
      end else begin
        write_reg(REG_SUPPLY, 48'($urandom_range(1, 4095)));
        write_reg(REG_SERIES, 48'($urandom_range(1, 1000000)));
        // Mostly perturbed real coefficients; sometimes fully random.
        coef_pick = ($urandom_range(0, 2) == 0) ? rand_coef()
                  : 48'(COEF_A_RST) + 48'($urandom_range(0, 1 << 30)) - 48'(1 << 29);
        write_reg(REG_COEF_A, coef_pick);
        coef_pick = ($urandom_range(0, 2) == 0) ? rand_coef()
                  : 48'(COEF_B_RST) + 48'($urandom_range(0, 1 << 30)) - 48'(1 << 29);
        write_reg(REG_COEF_B, coef_pick);
        write_reg(REG_COEF_C, ($urandom_range(0, 2) == 0) ? rand_coef()
                              : 48'(COEF_C_RST) + 48'($urandom_range(0, 1 << 20)));
        write_reg(REG_KOFF, 48'(($urandom_range(0, 1) == 0) ? KOFF_RST : 16'($urandom())));
      end
      for (int n = 0; n < 100; n++) begin
        // After twenty words of phase 2, stop the receiver so the pipe fills.
        if (phase == 2 && n == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (200) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        // Mostly in-range voltages; every bit still toggles across the run.
        if ($urandom_range(0, 7) == 0) send_paced(12'($urandom()), burst_left);
        else send_paced(12'($urandom_range(1, sh_supply > 1 ? sh_supply - 1 : 1)),
                        burst_left);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hdl
hdl/thm_pkg.sv
hdl/thm_if.sv
hdl/thm_log2.sv
hdl/thm_poly.sv
hdl/thm_div.sv
hdl/thermistor_temperature.sv
tb/testbench.sv
